// ===== hdl/tacm_pkg.sv =====
`default_nettype none
package tacm_pkg;

  localparam int FRAC_BITS_DEF = 8;

  localparam int POS_W      = 24;
  localparam int DRV_W      = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int MUL_W      = 33;
  localparam int PROD_W     = 2 * MUL_W;

  localparam logic [15:0] SCALE_RST = 16'd256;
  localparam logic [15:0] TOL_RST   = 16'd128;
  localparam logic [7:0]  VEL_RST   = 8'd50;

  localparam logic [CFG_IDX_W-1:0] REG_SCALE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TOL   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VEL   = 2'd2;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_TICK  = 1'b1;

  typedef struct packed {
    logic [15:0] counts_to_mm_scale;
    logic [15:0] tolerance_mm;
    logic [7:0]  velocity;
  } cfg_t;

  typedef struct packed {
    logic                    cmd;
    logic signed [POS_W-1:0] target_x;
    logic signed [POS_W-1:0] target_y;
    logic signed [POS_W-1:0] count_x;
    logic signed [POS_W-1:0] count_y;
  } in_item_t;

  typedef struct packed {
    logic signed [DRV_W-1:0] drive_x;
    logic signed [DRV_W-1:0] drive_y;
    logic                    moving;
    logic                    finished;
  } out_item_t;

endpackage
`default_nettype wire

// ===== hdl/tacm_stream_if.sv =====
`default_nettype none
interface tacm_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== hdl/tacm_cfg.sv =====
`default_nettype none
module tacm_cfg (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             we,
  input  wire logic [tacm_pkg::CFG_IDX_W-1:0]   idx,
  input  wire logic [tacm_pkg::CFG_DATA_W-1:0]  data,
  output tacm_pkg::cfg_t                        cfg
);

  tacm_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.counts_to_mm_scale <= tacm_pkg::SCALE_RST;
      cfg_r.tolerance_mm       <= tacm_pkg::TOL_RST;
      cfg_r.velocity           <= tacm_pkg::VEL_RST;
    end else if (we) begin
      unique case (idx)
        tacm_pkg::REG_SCALE: cfg_r.counts_to_mm_scale <= data;
        tacm_pkg::REG_TOL:   cfg_r.tolerance_mm       <= data;
        tacm_pkg::REG_VEL:   cfg_r.velocity           <= data[7:0];
        default: begin
        end
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire

// ===== hdl/tacm_mul.sv =====
`default_nettype none
module tacm_mul (
  input  wire logic                                clk,
  input  wire logic signed [tacm_pkg::MUL_W-1:0]   a,
  input  wire logic signed [tacm_pkg::MUL_W-1:0]   b,
  output logic signed [tacm_pkg::PROD_W-1:0]       prod
);

  logic signed [tacm_pkg::PROD_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    prod_r <= a * b;
  end

  assign prod = prod_r;

endmodule
`default_nettype wire

// ===== hdl/two_axis_tolerance_move_controller.sv =====
// Tick item, or start with no axis above tolerance: MX, MY, PY, DLT, EVAL, then result in END.
// Start with an axis above tolerance: EVAL goes on to SQX, SQY and SUM, then the search;
// each driven axis runs a 7-step quotient search on the shared 33x33 multiplier.
// A stalled result holds the next item in END until it is taken. One item in flight; ready again the cycle
// after its result is loaded.
// Synchronous active-low reset: config to defaults, move idle, goal and drives zero.
`default_nettype none
module two_axis_tolerance_move_controller #(
  parameter int POSITION_FRAC_BITS = tacm_pkg::FRAC_BITS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire logic [tacm_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  wire logic [tacm_pkg::CFG_DATA_W-1:0]  cfg_data,
  tacm_stream_if.sink                           in_chan,
  tacm_stream_if.source                         out_chan
);

  localparam int SHIFT = 16 - POSITION_FRAC_BITS;
  localparam int TOLW  = 16 + POSITION_FRAC_BITS;
  localparam int CMPW  = 33;
  localparam int MW    = tacm_pkg::MUL_W;
  localparam int PW    = tacm_pkg::PROD_W;

  localparam logic [4:0] ST_IDLE = 5'd0;
  localparam logic [4:0] ST_MX   = 5'd1;
  localparam logic [4:0] ST_MY   = 5'd2;
  localparam logic [4:0] ST_PY   = 5'd3;
  localparam logic [4:0] ST_DLT  = 5'd4;
  localparam logic [4:0] ST_EVAL = 5'd5;
  localparam logic [4:0] ST_SQX  = 5'd6;
  localparam logic [4:0] ST_SQY  = 5'd7;
  localparam logic [4:0] ST_SUM  = 5'd8;
  localparam logic [4:0] ST_VA   = 5'd9;
  localparam logic [4:0] ST_NA   = 5'd10;
  localparam logic [4:0] ST_NUM  = 5'd11;
  localparam logic [4:0] ST_T2   = 5'd12;
  localparam logic [4:0] ST_PH   = 5'd13;
  localparam logic [4:0] ST_PL   = 5'd14;
  localparam logic [4:0] ST_CMP  = 5'd15;
  localparam logic [4:0] ST_END  = 5'd16;

  function automatic logic signed [23:0] sat_pos(input logic signed [PW-1:0] p);
    logic signed [PW-1:0] q;
    begin
      q = p >>> SHIFT;
      if (q > 66'sd8388607) return 24'sh7FFFFF;
      else if (q < -66'sd8388608) return 24'sh800000;
      else return q[23:0];
    end
  endfunction

  function automatic logic [23:0] mag(input logic signed [24:0] v);
    logic signed [24:0] n;
    begin
      n = -v;
      return v[24] ? n[23:0] : v[23:0];
    end
  endfunction

  tacm_pkg::cfg_t cfg;

  logic [4:0] state_r, state_nxt;

  logic                 cmd_r;
  logic signed [23:0]   cnt_x_r, cnt_y_r, goal_x_r, goal_y_r, pos_x_r, pos_y_r;
  logic signed [24:0]   dx_r, dy_r;
  logic signed [7:0]    held_x_r, held_y_r, drv_x_r, drv_y_r;
  logic                 active_r, axis_r;
  logic [47:0]          ax2_r;
  logic [48:0]          s_r;
  logic [63:0]          num_r;
  logic [6:0]           q_r, bit_r, trial, q_fin;
  logic [13:0]          t2_r;
  logic [31:0]          ph_r;
  logic [63:0]          lhs;
  logic                 pass, trial_big, axis_done, next_y;
  logic signed [7:0]    q_s, drv_fin;

  logic [23:0]          adx, ady, ad_cur;
  logic [TOLW-1:0]      tol;
  logic                 gtx, gty, ltx, lty;

  logic signed [MW-1:0] mul_a, mul_b;
  logic signed [PW-1:0] prod;

  tacm_pkg::out_item_t  out_r;
  logic                 out_valid_r;
  logic                 in_acc, go, idle_tick, endc;
  logic signed [7:0]    hx, hy;
  logic signed [23:0]   neg_tx;

  tacm_cfg u_cfg (
    .clk  (clk),
    .rst_n(rst_n),
    .we   (cfg_we),
    .idx  (cfg_idx),
    .data (cfg_data),
    .cfg  (cfg)
  );

  tacm_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .prod(prod)
  );

  assign in_chan.ready    = (state_r == ST_IDLE);
  assign in_acc           = in_chan.valid && (state_r == ST_IDLE);
  assign out_chan.valid   = out_valid_r;
  assign out_chan.payload = out_r;
  assign go               = !out_valid_r || out_chan.ready;

  assign neg_tx = (in_chan.payload.target_x == 24'sh800000) ? 24'sh7FFFFF
                                                             : -in_chan.payload.target_x;

  assign adx    = mag(dx_r);
  assign ady    = mag(dy_r);
  assign ad_cur = axis_r ? ady : adx;
  assign tol    = (TOLW'(cfg.tolerance_mm) << POSITION_FRAC_BITS) >> 8;
  assign gtx    = CMPW'(adx) > CMPW'(tol);
  assign gty    = CMPW'(ady) > CMPW'(tol);
  assign ltx    = CMPW'(adx) < CMPW'(tol);
  assign lty    = CMPW'(ady) < CMPW'(tol);

  // quotient search, one bit per trial, MSB first
  assign trial     = q_r | bit_r;
  assign trial_big = trial > 7'd100;
  assign lhs       = {ph_r, 32'd0} + 64'(prod[45:0]);
  assign pass      = lhs <= num_r;
  assign axis_done = bit_r[0] && (((state_r == ST_T2) && trial_big) || (state_r == ST_CMP));
  assign q_fin     = ((state_r == ST_CMP) && pass) ? trial : q_r;
  assign q_s       = {1'b0, q_fin};
  assign drv_fin   = (axis_r ? dy_r[24] : dx_r[24]) ? -q_s : q_s;
  assign next_y    = !axis_r && gty;

  assign idle_tick = (cmd_r == tacm_pkg::CMD_TICK) && !active_r;
  assign hx   = (cmd_r == tacm_pkg::CMD_START) ? drv_x_r : (ltx ? 8'sd0 : held_x_r);
  assign hy   = (cmd_r == tacm_pkg::CMD_START) ? drv_y_r : (lty ? 8'sd0 : held_y_r);
  assign endc = (ltx && lty) || ((hx == 8'sd0) && (hy == 8'sd0));

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      ST_MX: begin
        mul_a = MW'(cnt_x_r);
        mul_b = MW'(cfg.counts_to_mm_scale);
      end
      ST_MY: begin
        mul_a = MW'(cnt_y_r);
        mul_b = MW'(cfg.counts_to_mm_scale);
      end
      ST_SQX: begin
        mul_a = MW'(adx);
        mul_b = MW'(adx);
      end
      ST_SQY: begin
        mul_a = MW'(ady);
        mul_b = MW'(ady);
      end
      ST_SUM, ST_VA: begin
        mul_a = MW'(cfg.velocity);
        mul_b = MW'(ad_cur);
      end
      ST_NA: begin
        mul_a = MW'(prod[31:0]);
        mul_b = MW'(prod[31:0]);
      end
      ST_T2: begin
        mul_a = MW'(trial);
        mul_b = MW'(trial);
      end
      ST_PH: begin
        mul_a = MW'(prod[13:0]);
        mul_b = MW'(s_r[48:32]);
      end
      ST_PL: begin
        mul_a = MW'(t2_r);
        mul_b = MW'(s_r[31:0]);
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_acc) state_nxt = ST_MX;
      ST_MX:   state_nxt = ST_MY;
      ST_MY:   state_nxt = ST_PY;
      ST_PY:   state_nxt = ST_DLT;
      ST_DLT:  state_nxt = ST_EVAL;
      ST_EVAL: begin
        if ((cmd_r == tacm_pkg::CMD_START) && (gtx || gty)) state_nxt = ST_SQX;
        else state_nxt = ST_END;
      end
      ST_SQX:  state_nxt = ST_SQY;
      ST_SQY:  state_nxt = ST_SUM;
      ST_SUM:  state_nxt = ST_NA;
      ST_VA:   state_nxt = ST_NA;
      ST_NA:   state_nxt = ST_NUM;
      ST_NUM:  state_nxt = ST_T2;
      ST_T2: begin
        if (!trial_big) state_nxt = ST_PH;
        else if (bit_r[0]) state_nxt = next_y ? ST_VA : ST_END;
        else state_nxt = ST_T2;
      end
      ST_PH:   state_nxt = ST_PL;
      ST_PL:   state_nxt = ST_CMP;
      ST_CMP: begin
        if (bit_r[0]) state_nxt = next_y ? ST_VA : ST_END;
        else state_nxt = ST_T2;
      end
      ST_END:  if (go) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      active_r    <= 1'b0;
      held_x_r    <= '0;
      held_y_r    <= '0;
      goal_x_r    <= '0;
      goal_y_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (in_acc && (in_chan.payload.cmd == tacm_pkg::CMD_START)) begin
        goal_x_r <= neg_tx;
        goal_y_r <= in_chan.payload.target_y;
      end
      if ((state_r == ST_END) && go) begin
        out_valid_r <= 1'b1;
        if (!idle_tick) begin
          held_x_r <= endc ? 8'sd0 : hx;
          held_y_r <= endc ? 8'sd0 : hy;
          active_r <= !endc;
        end
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_r   <= in_chan.payload.cmd;
      cnt_x_r <= in_chan.payload.count_x;
      cnt_y_r <= in_chan.payload.count_y;
    end
    if ((state_r == ST_END) && go) begin
      if (idle_tick) begin
        out_r <= '0;
      end else begin
        out_r.drive_x  <= endc ? 8'sd0 : hx;
        out_r.drive_y  <= endc ? 8'sd0 : hy;
        out_r.moving   <= !endc;
        out_r.finished <= endc;
      end
    end
    plain_steps : begin
      case (state_r)
        ST_MY:   pos_x_r <= sat_pos(prod);
        ST_PY:   pos_y_r <= sat_pos(prod);
        ST_DLT: begin
          dx_r <= 25'(goal_x_r) - 25'(pos_x_r);
          dy_r <= 25'(goal_y_r) - 25'(pos_y_r);
        end
        ST_EVAL: begin
          drv_x_r <= '0;
          drv_y_r <= '0;
          axis_r  <= !gtx;
        end
        ST_SQY:  ax2_r <= prod[47:0];
        ST_SUM:  s_r   <= 49'(ax2_r) + 49'(prod[47:0]);
        ST_NUM: begin
          num_r <= prod[63:0];
          q_r   <= '0;
          bit_r <= 7'b1000000;
        end
        ST_T2:   if (trial_big) bit_r <= bit_r >> 1;
        ST_PH:   t2_r <= prod[13:0];
        ST_PL:   ph_r <= prod[31:0];
        ST_CMP: begin
          if (pass) q_r <= trial;
          bit_r <= bit_r >> 1;
        end
        default: begin
        end
      endcase
      if (axis_done) begin
        if (axis_r) drv_y_r <= drv_fin;
        else drv_x_r <= drv_fin;
        axis_r <= 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== hdl/tacm_checker.sv =====
`default_nettype none
module tacm_checker (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_valid,
  input wire logic                in_ready,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire tacm_pkg::out_item_t out_payload
);

  // one item at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input still ready after an item was taken");

  a_finish_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_payload.finished |->
      !out_payload.moving && (out_payload.drive_x == 8'sd0) && (out_payload.drive_y == 8'sd0))
    else $error("finished item with drive or moving set");

  a_drive_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_payload.drive_x >= -8'sd100) && (out_payload.drive_x <= 8'sd100) &&
                  (out_payload.drive_y >= -8'sd100) && (out_payload.drive_y <= 8'sd100))
    else $error("drive out of range");

  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> in_ready)
    else $error("result issued while sequencer busy");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_payload))
    else $error("stalled result changed");

endmodule

bind two_axis_tolerance_move_controller tacm_checker u_tacm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_chan.valid),
  .in_ready   (in_chan.ready),
  .out_valid  (out_chan.valid),
  .out_ready  (out_chan.ready),
  .out_payload(out_chan.payload)
);
`default_nettype wire

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
module tb;
  import tacm_pkg::*;

  localparam int FRAC = FRAC_BITS_DEF;
  localparam longint POS_MAX = (longint'(1) <<< (POS_W - 1)) - 1;
  localparam longint POS_MIN = -(longint'(1) <<< (POS_W - 1));
  localparam logic [CFG_IDX_W-1:0] REG_NONE = 2'd3;
  localparam int WATCHDOG = 4000;
  localparam int TAIL = 100;
  localparam int RANDOM_END = 680;
  localparam int STEADY_LEN = 80;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  tacm_stream_if #(.T(in_item_t)) in_if ();
  tacm_stream_if #(.T(out_item_t)) out_if ();

  two_axis_tolerance_move_controller #(.POSITION_FRAC_BITS(FRAC)) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .in_chan  (in_if),
    .out_chan (out_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state and shadow registers
  logic [15:0] scale_q = SCALE_RST;
  logic [15:0] tol_q = TOL_RST;
  logic [7:0] vel_q = VEL_RST;
  logic signed [POS_W-1:0] goal_x_q = '0;
  logic signed [POS_W-1:0] goal_y_q = '0;
  logic signed [DRV_W-1:0] drv_x_q = '0;
  logic signed [DRV_W-1:0] drv_y_q = '0;
  logic active_q = 1'b0;

  out_item_t due_results[$];
  out_item_t want;
  out_item_t seen;
  int unsigned fails = 0;
  int sent = 0;
  int gap_pct = 25;
  int stall_pct = 25;

  function automatic longint sat_pos(input longint v);
    if (v > POS_MAX) return POS_MAX;
    if (v < POS_MIN) return POS_MIN;
    return v;
  endfunction

  function automatic longint magnitude(input longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic longint count_pos(input logic signed [POS_W-1:0] c);
    longint p;
    p = longint'(c) * longint'({48'd0, scale_q});
    return sat_pos(p >>> (16 - FRAC));
  endfunction

  function automatic longint tol_units();
    return (longint'({48'd0, tol_q}) <<< FRAC) >>> 8;
  endfunction

  // largest q <= 100 with q^2 * (d^2 + o^2) <= v^2 * d^2, signed as d
  function automatic logic signed [DRV_W-1:0] axis_power(input longint d, input longint o);
    logic [127:0] ad, ao, s, num, qq;
    int q;
    ad = magnitude(d);
    ao = magnitude(o);
    s = ad * ad + ao * ao;
    num = vel_q;
    num = num * num * ad * ad;
    q = 0;
    qq = 1;
    while (q < 100 && qq * s <= num) begin
      q++;
      qq = (q + 1) * (q + 1);
    end
    return (d < 0) ? -q : q;
  endfunction

  function automatic out_item_t move_step(input in_item_t it);
    longint tol, dx, dy;
    out_item_t r;
    r = '0;
    tol = tol_units();
    if (it.cmd == CMD_START || active_q) begin
      if (it.cmd == CMD_START) begin
        goal_x_q = sat_pos(-longint'(it.target_x));
        goal_y_q = it.target_y;
      end
      dx = longint'(goal_x_q) - count_pos(it.count_x);
      dy = longint'(goal_y_q) - count_pos(it.count_y);
      if (it.cmd == CMD_START) begin
        drv_x_q = (magnitude(dx) > tol) ? axis_power(dx, dy) : '0;
        drv_y_q = (magnitude(dy) > tol) ? axis_power(dy, dx) : '0;
        active_q = 1'b1;
      end else begin
        if (magnitude(dx) < tol) drv_x_q = '0;
        if (magnitude(dy) < tol) drv_y_q = '0;
      end
      if ((magnitude(dx) < tol && magnitude(dy) < tol) || (drv_x_q == 0 && drv_y_q == 0)) begin
        drv_x_q = '0;
        drv_y_q = '0;
        active_q = 1'b0;
        r.finished = 1'b1;
      end
      r.drive_x = drv_x_q;
      r.drive_y = drv_y_q;
      r.moving = active_q;
    end
    return r;
  endfunction

  // encoder count that lands near a wanted position
  function automatic logic signed [POS_W-1:0] count_for(input longint p);
    if (scale_q == 0) return $urandom();
    return sat_pos((p <<< (16 - FRAC)) / longint'({48'd0, scale_q}));
  endfunction

  function automatic longint rand_in(input longint span);
    return longint'($urandom_range(0, 2 * span)) - span;
  endfunction

  task automatic send_item(input logic cmd, input logic signed [POS_W-1:0] tx, ty, cx, cy);
    in_item_t it;
    int n;
    it.cmd = cmd;
    it.target_x = tx;
    it.target_y = ty;
    it.count_x = cx;
    it.count_y = cy;
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      n = $urandom_range(1, 17);
      in_if.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.payload <= it;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    due_results.push_back(move_step(it));
    sent++;
  endtask

  task automatic send_noise();
    send_item(logic'($urandom_range(0, 1)), $urandom(), $urandom(), $urandom(), $urandom());
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_SCALE: scale_q = data;
      REG_TOL:   tol_q = data;
      REG_VEL:   vel_q = data[7:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [15:0] scale, input logic [15:0] tol, input logic [7:0] vel);
    write_reg(REG_SCALE, scale);
    write_reg(REG_TOL, tol);
    write_reg(REG_VEL, {8'($urandom()), vel});
  endtask

  // start from a random place, then ticks that close in on the goal
  task automatic run_move();
    longint gx, gy, sx, sy, px, py, span, slack;
    int steps;
    span = longint'(1) << $urandom_range(3, 21);
    gx = rand_in(span);
    gy = rand_in(span);
    sx = rand_in(span);
    sy = ($urandom_range(0, 3) == 0) ? gy : rand_in(span);
    send_item(CMD_START, sat_pos(-gx), gy, count_for(sx), count_for(sy));
    steps = $urandom_range(1, 8);
    for (int k = 1; k <= steps; k++) begin
      if ($urandom_range(0, 19) == 0) return;
      if ($urandom_range(0, 19) == 0) send_noise();
      slack = tol_units() / 2;
      px = sx + (gx - sx) * k / steps + rand_in(slack);
      py = sy + (gy - sy) * k / steps + rand_in(slack);
      send_item(CMD_TICK, $urandom(), $urandom(), count_for(px), count_for(py));
    end
    if ($urandom_range(0, 3) == 0)
      send_item(CMD_TICK, $urandom(), $urandom(), $urandom(), $urandom());
  endtask

  task automatic test_idle_and_zero();
    send_item(CMD_TICK, $urandom(), $urandom(), $urandom(), $urandom());
    send_item(CMD_START, '0, '0, '0, '0);
    send_item(CMD_TICK, 24'sd1000, -24'sd1000, 24'sd5, -24'sd5);
  endtask

  task automatic test_default_moves();
    send_item(CMD_START, -24'sd1000, '0, '0, '0);
    send_item(CMD_TICK, '0, '0, 24'sd500, '0);
    send_item(CMD_TICK, '0, '0, 24'sd1000, '0);
    // start a new move, then restart while it is running
    send_item(CMD_START, -24'sd5000, 24'sd3000, '0, '0);
    send_item(CMD_START, 24'sd2000, -24'sd2000, 24'sd100, 24'sd100);
    send_item(CMD_TICK, '0, '0, -24'sd1990, 24'sd100);
    send_item(CMD_TICK, '0, '0, -24'sd2000, -24'sd2000);
    send_item(CMD_START, '0, 24'sd7000, '0, 24'sd100);
    send_item(CMD_TICK, '0, '0, 24'sd3, 24'sd6950);
  endtask

  task automatic test_config_extremes();
    drain();
    set_config(16'hFFFF, 16'h0000, 8'hFF);
    // negating the most negative target saturates
    send_item(CMD_START, 24'h800000, 24'h7FFFFF, 24'h800000, 24'h800000);
    send_item(CMD_TICK, '0, '0, 24'h7FFFFF, 24'h7FFFFF);
    send_item(CMD_TICK, '0, '0, 24'h7FFFFF, 24'h800000);
    send_item(CMD_START, 24'h7FFFFF, 24'h800000, 24'h7FFFFF, 24'h7FFFFF);
    drain();
    set_config(SCALE_RST, TOL_RST, 8'd1);
    // both drives truncate to zero, and a lone axis gets full speed
    send_item(CMD_START, -24'sd1000, 24'sd1000, '0, '0);
    send_item(CMD_START, -24'sd1000, '0, '0, '0);
    drain();
    set_config(16'h0000, 16'hFFFF, 8'd0);
    write_reg(REG_NONE, 16'($urandom()));
    send_item(CMD_START, $urandom(), $urandom(), $urandom(), $urandom());
    send_item(CMD_TICK, $urandom(), $urandom(), $urandom(), $urandom());
  endtask

  task automatic test_random_moves();
    int phase;
    int pcts[3];
    pcts = '{0, 10, 40};
    phase = 0;
    while (sent < RANDOM_END) begin
      drain();
      case (phase)
        0: set_config(16'h0000, 16'($urandom()), 8'($urandom()));
        1: set_config(16'hFFFF, 16'h0000, 8'hFF);
        2: set_config(16'h0001, 16'hFFFF, 8'h00);
        3: set_config(SCALE_RST, TOL_RST, VEL_RST);
        default: begin
          if ($urandom_range(0, 3) == 0)
            set_config(16'($urandom()), 16'($urandom()), 8'($urandom()));
          else
            set_config($urandom_range(16, 2048), $urandom_range(0, 1024), 8'($urandom()));
        end
      endcase
      gap_pct = pcts[$urandom_range(0, 2)];
      stall_pct = pcts[$urandom_range(0, 2)];
      repeat ($urandom_range(5, 15)) begin
        if ($urandom_range(0, 9) == 0) send_noise();
        else run_move();
      end
      phase++;
    end
  endtask

  task automatic test_steady_stream();
    int stop;
    drain();
    gap_pct = 0;
    stall_pct = 0;
    set_config($urandom_range(64, 1024), $urandom_range(16, 512), 8'($urandom()));
    stop = sent + STEADY_LEN;
    while (sent < stop) run_move();
  endtask

  initial begin : sink_side
    int n;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
        n = $urandom_range(1, 17);
        out_if.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_if.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      seen = out_if.payload;
      if (due_results.size() == 0) begin
        $error("result item with no input item outstanding");
        fails++;
      end else begin
        want = due_results.pop_front();
        if (seen.drive_x !== want.drive_x) begin
          $error("drive_x: expected %0d, got %0d", want.drive_x, seen.drive_x);
          fails++;
        end
        if (seen.drive_y !== want.drive_y) begin
          $error("drive_y: expected %0d, got %0d", want.drive_y, seen.drive_y);
          fails++;
        end
        if (seen.moving !== want.moving) begin
          $error("moving: expected %0d, got %0d", want.moving, seen.moving);
          fails++;
        end
        if (seen.finished !== want.finished) begin
          $error("finished: expected %0d, got %0d", want.finished, seen.finished);
          fails++;
        end
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG) begin
      @(posedge clk);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) quiet = 0;
      else quiet++;
    end
    $display("Verification failed");
    $finish;
  end

  initial begin
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_idx <= '0;
    cfg_data <= '0;
    in_if.valid <= 1'b0;
    in_if.payload <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_idle_and_zero();
    test_default_moves();
    test_config_extremes();
    test_random_moves();
    test_steady_stream();
    drain();
    repeat (TAIL) @(posedge clk);
    if (fails == 0 && due_results.size() == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule

// ===== files.f =====
hdl/tacm_pkg.sv
hdl/tacm_stream_if.sv
hdl/tacm_cfg.sv
hdl/tacm_mul.sv
hdl/two_axis_tolerance_move_controller.sv
hdl/tacm_checker.sv
verif/tb.sv
